[hdl/lpfr_pkg.sv]
`default_nettype none

package lpfr_pkg;

  // Receive phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_RECV = 4'b0010,
    PH_DONE = 4'b0100,
    PH_ERR  = 4'b1000
  } phase_e;

  // Request codes on the input channel
  typedef enum logic [1:0] {
    REQ_FRAG    = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_IGNORED = 3'd1,
    ST_DROPPED = 3'd2,
    ST_ERROR   = 3'd3,
    ST_READ    = 3'd4,
    ST_RESTART = 3'd5
  } status_e;

  // Header decoding
  localparam logic [7:0]  HDR_LONG_MARK  = 8'hFF;
  localparam logic [7:0]  HDR_LONG_MUL   = 8'hFE;
  localparam logic [1:0]  HDR_LONG_SIZE  = 2'd3;
  localparam logic [1:0]  HDR_SHORT_SIZE = 2'd1;
  localparam logic [11:0] FIRST_MIN_LEN  = 12'd3;

  // Output buffer
  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  // Result before the store read data is merged in
  typedef struct packed {
    status_e     status;
    logic        packet_done;
    logic [15:0] payload_len;
    logic [1:0]  header_size;
    logic        rd_hit;
  } res_t;

  // Complete result item
  typedef struct packed {
    status_e     status;
    logic        packet_done;
    logic [15:0] payload_len;
    logic [1:0]  header_size;
    logic [7:0]  read_byte;
  } out_t;

endpackage

`default_nettype wire

[hdl/lpfr_if.sv]
`default_nettype none

// Request channel
interface lpfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  data_byte;
  logic        frag_first;
  logic [11:0] frag_len;
  logic [10:0] read_index;

  modport source (
    output valid, req_type, data_byte, frag_first, frag_len, read_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, data_byte, frag_first, frag_len, read_index,
    output ready
  );
endinterface

// Result channel
interface lpfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        packet_done;
  logic [15:0] payload_len;
  logic [1:0]  header_size;
  logic [7:0]  read_byte;

  modport source (
    output valid, status, packet_done, payload_len, header_size, read_byte,
    input  ready
  );
  modport sink (
    input  valid, status, packet_done, payload_len, header_size, read_byte,
    output ready
  );
endinterface

`default_nettype wire

[hdl/lpfr_out_fifo.sv]
`default_nettype none

module lpfr_out_fifo import lpfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  out_t             push_data_i,
  output logic [CNT_W-1:0] count_o,
  lpfr_out_if.source       out_o
);

  out_t             entries_q [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             pop;

  assign pop = out_o.valid && out_o.ready;

  // Present the oldest item
  assign out_o.valid       = (cnt_q != '0);
  assign out_o.status      = entries_q[rd_ptr_q].status;
  assign out_o.packet_done = entries_q[rd_ptr_q].packet_done;
  assign out_o.payload_len = entries_q[rd_ptr_q].payload_len;
  assign out_o.header_size = entries_q[rd_ptr_q].header_size;
  assign out_o.read_byte   = entries_q[rd_ptr_q].read_byte;
  assign count_o           = cnt_q;

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (!push_i && pop) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/length_prefixed_fragment_reassembler_top.sv]
// Length-prefixed packet reassembler.
// in_i carries one request item per handshake: a fragment byte, a read of a
// stored payload byte, or a restart. out_o returns exactly one result item
// per request, in order, with the status and the packet state after it.
// The first byte of a fragment carries frag_first and frag_len. Packet bytes
// go to a single-port-write, single-port-read store of STORE_DEPTH bytes,
// at most one write per fragment byte; a read request reads the store once.
// Each result is registered first with the synchronous store read and then
// in the output buffer before it appears on out_o.
// Throughput: one item per cycle while in_i.ready is high, set by the one store access per item;
// all control state updates within the accepting cycle.
// A four-entry output buffer holds results while the receiver stalls;
// in_i.ready drops only when four results are outstanding, and it is
// derived from registers alone.
// Reset clears the receive state and the output buffer; the store is not
// cleared, and only entries written for the current packet are ever read.
// A restart request clears all receive state except the store.
`default_nettype none

module length_prefixed_fragment_reassembler_top import lpfr_pkg::*; #(
  parameter int STORE_DEPTH = 2048
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpfr_in_if.sink    in_i,
  lpfr_out_if.source out_o
);

  localparam int          AW      = $clog2(STORE_DEPTH);
  localparam logic [16:0] DEPTH_L = 17'(STORE_DEPTH);

  // Receive state
  phase_e      ph_q, ph_d;
  logic [7:0]  hdr_q [2];
  logic [7:0]  hdr_d [2];
  logic [15:0] tot_q, tot_d;
  logic [15:0] rc_q, rc_d;
  logic [1:0]  ps_q, ps_d;
  logic [15:0] pl_q, pl_d;
  logic [11:0] fr_q, fr_d;
  logic        drop_q, drop_d;

  // Store
  logic [7:0]    store_mem [STORE_DEPTH];
  logic          mem_we, mem_re;
  logic [16:0]   wa_full, ra_full;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    rd_q;

  // Pipeline and output
  logic             in_fire;
  status_e          st;
  logic             rd_hit;
  logic             s1_valid_q;
  res_t             s1_res_q;
  out_t             push_data;
  logic [CNT_W-1:0] fifo_cnt;
  logic             ok;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = ({1'b0, fifo_cnt} + (CNT_W + 1)'(s1_valid_q))
                      < (CNT_W + 1)'(OUT_DEPTH);

  assign ra_full   = 17'(ps_q) + 17'(in_i.read_index);
  assign mem_waddr = wa_full[AW-1:0];
  assign mem_raddr = ra_full[AW-1:0];

  // Next receive state for the offered item
  always_comb begin
    ph_d    = ph_q;
    hdr_d   = hdr_q;
    tot_d   = tot_q;
    rc_d    = rc_q;
    ps_d    = ps_q;
    pl_d    = pl_q;
    fr_d    = fr_q;
    drop_d  = drop_q;
    st      = ST_IGNORED;
    rd_hit  = 1'b0;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    wa_full = {1'b0, rc_q};
    ok      = 1'b1;
    case (in_i.req_type)
      REQ_FRAG: begin
        if (ph_q == PH_IDLE) begin
          // first fragment: open it and decode the header at byte 2
          if (in_i.frag_first) begin
            rc_d   = '0;
            fr_d   = in_i.frag_len;
            drop_d = 1'b0;
            if (in_i.frag_len < FIRST_MIN_LEN) begin
              fr_d = '0;
              ph_d = PH_ERR;
              st   = ST_ERROR;
              ok   = 1'b0;
            end
          end else if (fr_q == '0) begin
            ok = 1'b0;
          end
          if (ok) begin
            if (rc_d < 16'd2) begin
              hdr_d[rc_d[0]] = in_i.data_byte;
            end else if (rc_d == 16'd2) begin
              if (in_i.data_byte == HDR_LONG_MARK) begin
                ps_d = HDR_LONG_SIZE;
                pl_d = 16'(hdr_q[0]) * 16'(HDR_LONG_MUL) + 16'(hdr_q[1]);
              end else begin
                ps_d = HDR_SHORT_SIZE;
                pl_d = 16'(hdr_q[0]);
              end
              tot_d = pl_d + 16'(ps_d);
              if (17'(tot_d) > DEPTH_L || 17'(fr_d) + 17'(rc_d) > 17'(tot_d)) begin
                fr_d = '0;
                ph_d = PH_ERR;
                st   = ST_ERROR;
                ok   = 1'b0;
              end
            end
          end
          if (ok) begin
            wa_full = {1'b0, rc_d};
            mem_we  = (wa_full < DEPTH_L);
            rc_d    = rc_d + 16'd1;
            fr_d    = fr_d - 12'd1;
            if (fr_d == '0) begin
              ph_d = (rc_d == tot_d) ? PH_DONE : PH_RECV;
            end
            st = ST_STORED;
          end
        end else if (ph_q == PH_RECV) begin
          // later fragment: drop it whole if it would pass the total
          if (in_i.frag_first) begin
            fr_d   = in_i.frag_len;
            drop_d = (17'(rc_q) + 17'(in_i.frag_len)) > 17'(tot_q);
            if (in_i.frag_len == '0) begin
              ok = 1'b0;
            end
          end else if (fr_q == '0) begin
            ok = 1'b0;
          end
          if (ok) begin
            fr_d = fr_d - 12'd1;
            if (drop_d) begin
              st = ST_DROPPED;
            end else begin
              mem_we = (wa_full < DEPTH_L);
              rc_d   = rc_q + 16'd1;
              if (rc_d == tot_q) begin
                ph_d = PH_DONE;
              end
              st = ST_STORED;
            end
          end
        end
      end
      REQ_READ: begin
        if (ph_q == PH_DONE && 16'(in_i.read_index) < pl_q && ra_full < DEPTH_L) begin
          mem_re = 1'b1;
          rd_hit = 1'b1;
          st     = ST_READ;
        end
      end
      REQ_RESTART: begin
        ph_d     = PH_IDLE;
        hdr_d[0] = '0;
        hdr_d[1] = '0;
        tot_d    = '0;
        rc_d     = '0;
        ps_d     = '0;
        pl_d     = '0;
        fr_d     = '0;
        drop_d   = 1'b0;
        st       = ST_RESTART;
      end
      default: begin
        st = ST_IGNORED;
      end
    endcase
  end

  // Update receive state on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_IDLE;
      hdr_q[0] <= '0;
      hdr_q[1] <= '0;
      tot_q    <= '0;
      rc_q     <= '0;
      ps_q     <= '0;
      pl_q     <= '0;
      fr_q     <= '0;
      drop_q   <= 1'b0;
    end else if (in_fire) begin
      ph_q   <= ph_d;
      hdr_q  <= hdr_d;
      tot_q  <= tot_d;
      rc_q   <= rc_d;
      ps_q   <= ps_d;
      pl_q   <= pl_d;
      fr_q   <= fr_d;
      drop_q <= drop_d;
    end
  end

  // Store packet bytes and read payload bytes
  always_ff @(posedge clk_i) begin
    if (in_fire && mem_we) begin
      store_mem[mem_waddr] <= in_i.data_byte;
    end
    if (in_fire && mem_re) begin
      rd_q <= store_mem[mem_raddr];
    end
  end

  // Hold the result while the store read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_res_q.status      <= st;
      s1_res_q.packet_done <= (ph_d == PH_DONE);
      s1_res_q.payload_len <= pl_d;
      s1_res_q.header_size <= ps_d;
      s1_res_q.rd_hit      <= rd_hit;
    end
  end

  // Merge the read byte and buffer the item
  always_comb begin
    push_data.status      = s1_res_q.status;
    push_data.packet_done = s1_res_q.packet_done;
    push_data.payload_len = s1_res_q.payload_len;
    push_data.header_size = s1_res_q.header_size;
    push_data.read_byte   = s1_res_q.rd_hit ? rd_q : 8'd0;
  end

  lpfr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (push_data),
    .count_o     (fifo_cnt),
    .out_o       (out_o)
  );

`ifndef ASSERT_OFF
  // A pushed item always finds room in the output buffer
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (fifo_cnt < CNT_W'(OUT_DEPTH)))
    else $error("output buffer overflow");

  // A done packet has received exactly its total
  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_DONE) |-> (rc_q == tot_q))
    else $error("done phase with count not at total");

  // No store write outside the receiving phases
  a_no_late_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mem_we) |-> (ph_q == PH_IDLE || ph_q == PH_RECV))
    else $error("store written in done or error phase");
`endif

endmodule

`default_nettype wire
